// ===== src/smsp_pkg.sv =====
// ----------------------------------------------------------------------------
// smsp_pkg
// Shared constants and controller/datapath interface types for the shuffled
// minimal-standard random source.
// ----------------------------------------------------------------------------
package smsp_pkg;

  // Generator word width and Park-Miller constants.
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned MULT_W  = 15;
  localparam int unsigned PROD_W  = VAL_W + MULT_W;
  localparam logic [MULT_W-1:0] MS_MULT = 15'd16807;
  localparam logic [VAL_W-1:0]  MS_MOD  = 31'h7FFF_FFFF;

  // Shuffle table geometry. The slot divisor is 2^(VAL_W - IDX_W), so the
  // slot is simply the top IDX_W bits of the previous output.
  localparam int unsigned TABLE_SIZE = 32;
  localparam int unsigned IDX_W      = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_seed;   // generator takes the cleaned-up seed
    logic             mul_en;      // product register takes generator * 16807
    logic             warm_fold;   // warm-up step completes
    logic             warm_wr;     // this warm-up step also fills a slot
    logic             warm_last;   // final warm-up step, last output takes it
    logic [IDX_W-1:0] warm_idx;    // slot written during warm-up
    logic             draw_fold;   // draw step completes and emits a sample
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_warm;               // generator or last output is zero
  } status_t;

endpackage

// ===== src/smsp_datapath.sv =====
// ----------------------------------------------------------------------------
// smsp_datapath
// Generator register, product register with Mersenne fold, shuffle memory,
// seed register and the sample output register.
// ----------------------------------------------------------------------------
module smsp_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [smsp_pkg::VAL_W-1:0]   cfg_wdata,
  input  smsp_pkg::cmd_t               cmd,
  output smsp_pkg::status_t            status,
  output logic [smsp_pkg::VAL_W-1:0]   sample
);

  logic [smsp_pkg::VAL_W-1:0]  seed;
  logic [smsp_pkg::VAL_W-1:0]  seed_clean;
  logic [smsp_pkg::VAL_W-1:0]  gen_value;
  logic [smsp_pkg::VAL_W-1:0]  last_output;
  logic [smsp_pkg::PROD_W-1:0] product;
  logic [smsp_pkg::VAL_W:0]    fold_sum;
  logic [smsp_pkg::VAL_W-1:0]  fold_value;
  logic [smsp_pkg::IDX_W-1:0]  slot;
  logic [smsp_pkg::IDX_W-1:0]  wr_addr;
  logic                        wr_en;
  logic [smsp_pkg::VAL_W-1:0]  rd_data;
  logic [smsp_pkg::VAL_W-1:0]  shuffle_mem [smsp_pkg::TABLE_SIZE];

  // Seed register; write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= smsp_pkg::VAL_W'(1);
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  // Zero and the modulus itself would pin the generator at zero.
  assign seed_clean = (seed == '0 || seed == smsp_pkg::MS_MOD) ?
                      smsp_pkg::VAL_W'(1) : seed;

  // Multiply stage: 31 x 15 bits into the product register.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      product <= smsp_pkg::PROD_W'(gen_value) * smsp_pkg::PROD_W'(smsp_pkg::MS_MULT);
    end
  end

  // Fold stage: 2^31 is congruent to 1, so add the high part to the low
  // part and subtract the modulus once if needed.
  assign fold_sum = {1'b0, product[smsp_pkg::VAL_W-1:0]}
                  + (smsp_pkg::VAL_W+1)'(product[smsp_pkg::PROD_W-1:smsp_pkg::VAL_W]);
  assign fold_value = (fold_sum >= {1'b0, smsp_pkg::MS_MOD}) ?
                      smsp_pkg::VAL_W'(fold_sum - {1'b0, smsp_pkg::MS_MOD}) :
                      fold_sum[smsp_pkg::VAL_W-1:0];

  // Generator and last output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_value   <= '0;
      last_output <= '0;
    end else begin
      if (cmd.load_seed) begin
        gen_value <= seed_clean;
      end else if (cmd.warm_fold || cmd.draw_fold) begin
        gen_value <= fold_value;
      end
      if (cmd.warm_fold && cmd.warm_last) begin
        last_output <= fold_value;
      end else if (cmd.draw_fold) begin
        last_output <= rd_data;
      end
    end
  end

  assign status.need_warm = (gen_value == '0) || (last_output == '0);

  // The previous output picks the slot from its top bits.
  assign slot = last_output[smsp_pkg::VAL_W-1 -: smsp_pkg::IDX_W];

  // Shuffle memory: one write port, one registered read port.
  assign wr_en   = (cmd.warm_fold && cmd.warm_wr) || cmd.draw_fold;
  assign wr_addr = cmd.draw_fold ? slot : cmd.warm_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      shuffle_mem[wr_addr] <= fold_value;
    end
    rd_data <= shuffle_mem[slot];
  end

  // Sample output register.
  always_ff @(posedge clk) begin
    if (cmd.draw_fold) begin
      sample <= rd_data;
    end
  end

endmodule

// ===== src/smsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// smsp_ctrl
// Sequencer for warm-up and draw steps, and the input/output handshakes.
// ----------------------------------------------------------------------------
module smsp_ctrl #(
  parameter int unsigned WARMUP_EXTRA = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  input  smsp_pkg::status_t  status,
  output smsp_pkg::cmd_t     cmd
);

  localparam int unsigned WARM_STEPS = smsp_pkg::TABLE_SIZE + WARMUP_EXTRA;
  // Wide enough to hold both the step count and the table size.
  localparam int unsigned CNT_W      = $clog2(WARM_STEPS + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_WARM_MUL  = 3'd1;
  localparam logic [2:0] S_WARM_FOLD = 3'd2;
  localparam logic [2:0] S_DRAW_WAIT = 3'd3;
  localparam logic [2:0] S_DRAW_MUL  = 3'd4;
  localparam logic [2:0] S_DRAW_FOLD = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (restart || status.need_warm) ? S_WARM_MUL : S_DRAW_WAIT;
        end
      end
      S_WARM_MUL:  state_next = S_WARM_FOLD;
      S_WARM_FOLD: state_next = (cnt == '0) ? S_DRAW_WAIT : S_WARM_MUL;
      S_DRAW_WAIT: begin
        if (!out_valid) begin
          state_next = S_DRAW_MUL;
        end
      end
      S_DRAW_MUL:  state_next = S_DRAW_FOLD;
      S_DRAW_FOLD: state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // State, warm-up step counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= CNT_W'(WARM_STEPS - 1);
      end else if (state == S_WARM_FOLD && cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
      if (state == S_DRAW_FOLD) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath commands.
  always_comb begin
    cmd.load_seed = accept && (restart || status.need_warm);
    cmd.mul_en    = (state == S_WARM_MUL) || (state == S_DRAW_MUL);
    cmd.warm_fold = (state == S_WARM_FOLD);
    cmd.warm_wr   = (cnt < CNT_W'(smsp_pkg::TABLE_SIZE));
    cmd.warm_last = (cnt == '0);
    cmd.warm_idx  = cnt[smsp_pkg::IDX_W-1:0];
    cmd.draw_fold = (state == S_DRAW_FOLD);
  end

endmodule

// ===== src/shuffled_minimal_standard_prng.sv =====
// Without warm-up, an accepted draw goes S_DRAW_WAIT, S_DRAW_MUL, S_DRAW_FOLD
// to out_valid, waiting in S_DRAW_WAIT while the last sample is unread. Draws
// never overlap. A warm-up (restart, or first draw after reset) first runs
// 32+WARMUP_EXTRA steps, each via the shared multiply register and fold adder.
// Reset: synchronous; seed returns to 1, generator and last output to zero, so
// the first draw always warms up. The shuffle memory is not cleared.
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_prng
// Park-Miller minimal-standard generator behind a Bays-Durham shuffle table,
// one 31-bit uniform sample per transaction.
// ----------------------------------------------------------------------------
module shuffled_minimal_standard_prng #(
  parameter int unsigned WARMUP_EXTRA = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [smsp_pkg::VAL_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [smsp_pkg::VAL_W-1:0]  sample
);

  smsp_pkg::cmd_t    cmd;
  smsp_pkg::status_t status;

  // Sequencer.
  smsp_ctrl #(
    .WARMUP_EXTRA (WARMUP_EXTRA)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, storage and output register.
  smsp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .sample    (sample)
  );

endmodule
